// ----- src/ldtc_pkg.sv -----
`timescale 1ns / 1ps

package ldtc_pkg;

    // operation codes carried in tuser
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SELECT = 2'd1;
    localparam logic [1:0] OP_WRITE  = 2'd2;
    localparam logic [1:0] OP_LATCH  = 2'd3;

    // register indexes
    localparam logic [2:0] REG_SEC  = 3'd0;
    localparam logic [2:0] REG_MIN  = 3'd1;
    localparam logic [2:0] REG_HOUR = 3'd2;
    localparam logic [2:0] REG_DL   = 3'd3;
    localparam logic [2:0] REG_DH   = 3'd4;
    localparam int NUM_REGS = 5;

    localparam int OP_W    = 2;
    localparam int VALUE_W = 8;
    localparam int DATA_W  = 8;

    // bit positions inside the dh register
    localparam int DH_DAY_BIT  = 0;
    localparam int DH_HALT_BIT = 6;
    localparam int DH_OVF_BIT  = 7;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
    } t_item;

endpackage

// ----- src/latched_day_time_clock_unit.sv -----
`timescale 1ns / 1ps
// an accepted item goes through the input register, then the result register;
// one item per cycle sustained while m_axis_tready does not stall the output
// throughput is set by the combinational clock update between the two registers
// reset (synchronous, active low) clears the live clock, halt and overflow bits,
// the latched registers and the select index; the latch history starts at zero

module latched_day_time_clock_unit
    import ldtc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [VALUE_W-1:0] s_axis_tdata,   // [7:0] value
    input  logic [OP_W-1:0]    s_axis_tuser,   // [1:0] op
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [DATA_W-1:0]  m_axis_tdata    // [7:0] read_data
);

    logic              r_in_vld;
    t_item             r_in_item;
    logic              r_out_vld;
    logic [DATA_W-1:0] r_out_data;
    logic              w_adv;
    logic [DATA_W-1:0] w_read_data;

    // item moves into the result register when that register is free or drained
    assign w_adv         = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item.op    <= s_axis_tuser;
            r_in_item.value <= s_axis_tdata;
        end
    end

    ldtc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_adv),
        .i_item      (r_in_item),
        .o_read_data (w_read_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= w_read_data;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- src/ldtc_core.sv -----
`timescale 1ns / 1ps

module ldtc_core
    import ldtc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_item             i_item,
    output logic [DATA_W-1:0] o_read_data
);

    localparam logic [6:0] SEC_MOD  = 7'd60;
    localparam logic [6:0] MIN_MOD  = 7'd60;
    localparam logic [5:0] HOUR_MOD = 6'd24;

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [8:0] day;
        logic       ovf;
    } t_time;

    t_time             r_time, n_time, w_norm;
    logic              r_halt, n_halt;
    logic [2:0]        r_sel, n_sel;
    logic              r_latch_zero, n_latch_zero;
    logic [DATA_W-1:0] r_latch [NUM_REGS];
    logic [DATA_W-1:0] n_latch [NUM_REGS];

    // add one second optionally, then carry each field at most once
    function automatic t_time f_normalize(input t_time t, input logic add);
        logic [6:0] s;
        logic [6:0] m;
        logic [5:0] h;
        logic [9:0] d;
        t_time      res;
        s = {1'b0, t.sec} + {6'd0, add};
        m = {1'b0, t.min};
        h = {1'b0, t.hour};
        d = {1'b0, t.day};
        res = t;
        if (s >= SEC_MOD) begin
            s = s - SEC_MOD;
            m = m + 7'd1;
        end
        if (m >= MIN_MOD) begin
            m = m - MIN_MOD;
            h = h + 6'd1;
        end
        if (h >= HOUR_MOD) begin
            h = h - HOUR_MOD;
            d = d + 10'd1;
        end
        if (d[9]) begin
            res.ovf = 1'b1;
        end
        res.sec  = s[5:0];
        res.min  = m[5:0];
        res.hour = h[4:0];
        res.day  = d[8:0];
        return res;
    endfunction

    assign w_norm = f_normalize(r_time, (i_item.op == OP_TICK));

    always_comb begin
        n_time       = r_time;
        n_halt       = r_halt;
        n_sel        = r_sel;
        n_latch_zero = r_latch_zero;
        for (int i = 0; i < NUM_REGS; i++) begin
            n_latch[i] = r_latch[i];
        end
        if (i_en) begin
            case (i_item.op)
                OP_TICK: begin
                    if (!r_halt) begin
                        n_time = w_norm;
                    end
                end
                OP_SELECT: begin
                    n_sel = i_item.value[2:0];
                end
                OP_WRITE: begin
                    n_time = w_norm;
                    case (r_sel)
                        REG_SEC:  n_time.sec  = i_item.value[5:0];
                        REG_MIN:  n_time.min  = i_item.value[5:0];
                        REG_HOUR: n_time.hour = i_item.value[4:0];
                        REG_DL:   n_time.day  = {w_norm.day[8], i_item.value};
                        REG_DH: begin
                            n_time.day[8] = i_item.value[DH_DAY_BIT];
                            n_time.ovf    = i_item.value[DH_OVF_BIT];
                            n_halt        = i_item.value[DH_HALT_BIT];
                        end
                        default: ;
                    endcase
                end
                OP_LATCH: begin
                    // copy happens on a 0 -> 1 change of the control byte
                    if (r_latch_zero && (i_item.value == 8'd1)) begin
                        n_time = w_norm;
                        n_latch[REG_SEC]  = {2'd0, w_norm.sec};
                        n_latch[REG_MIN]  = {2'd0, w_norm.min};
                        n_latch[REG_HOUR] = {3'd0, w_norm.hour};
                        n_latch[REG_DL]   = w_norm.day[7:0];
                        n_latch[REG_DH]   = {w_norm.ovf, r_halt, 5'd0, w_norm.day[8]};
                    end
                    n_latch_zero = (i_item.value == 8'd0);
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_read_data = '0;
        if (n_sel < 3'(NUM_REGS)) begin
            o_read_data = n_latch[n_sel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time       <= '0;
            r_halt       <= 1'b0;
            r_sel        <= '0;
            r_latch_zero <= 1'b1;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_latch[i] <= '0;
            end
        end else begin
            r_time       <= n_time;
            r_halt       <= n_halt;
            r_sel        <= n_sel;
            r_latch_zero <= n_latch_zero;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_latch[i] <= n_latch[i];
            end
        end
    end

`ifndef SYNTHESIS
    a_halted_tick_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && (i_item.op == OP_TICK) && r_halt |=> $stable(r_time))
        else $error("tick advanced a halted clock");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && (i_item.op == OP_TICK) && r_time.ovf |=> r_time.ovf)
        else $error("day overflow cleared by a tick");

    a_select_keeps_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && (i_item.op == OP_SELECT) |=> $stable(r_time) && $stable(r_halt))
        else $error("register select changed the live clock");

    a_latch_zero_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && (i_item.op == OP_LATCH) |=>
            r_latch_zero == ($past(i_item.value) == 8'd0))
        else $error("latch control history wrong");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_time) && $stable(r_sel) && $stable(r_latch_zero))
        else $error("state changed without an item");
`endif

endmodule
